FILE: src/qmi_pkg.sv
// Shared types and sizing constants for the queue with middle insert.
`default_nettype none

package qmi_pkg;

  // Queue sizing
  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned HALF_DEPTH = (CAPACITY + 1) / 2;
  localparam int unsigned IDX_W      = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(HALF_DEPTH + 1);
  localparam int unsigned N_W        = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W     = 32;

  // Operation codes carried in the input item
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_INSERT = 2'd2
  } opcode_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_MOVE = 1'b1
  } qmi_state_e;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] value;
  } qmi_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [1:0]               status;
  } qmi_out_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    exec;       // item accepted: latch value, issue reads
    logic    push_tail;  // write value at back tail
    logic    push_head;  // write value in front of back head
    logic    pop;        // read and drop front head
    logic    fin;        // load result register
    logic    move;       // move back head to front tail
    logic    pop_ok;     // result carries the popped value
    status_e status;     // result status
  } qmi_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic few;        // fewer than two entries
    logic need_move;  // back half longer than front half
  } qmi_stat_t;

endpackage

`default_nettype wire

FILE: src/qmi_datapath.sv
// Datapath: the two half rings, their pointers and the result register.
`default_nettype none

module qmi_datapath (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  qmi_pkg::qmi_cmd_t        cmd_i,
  input  wire signed [31:0]        value_i,
  output qmi_pkg::qmi_stat_t       stat_o,
  output qmi_pkg::qmi_out_t        result_o
);
  import qmi_pkg::*;

  localparam int unsigned SUM_W = CNT_W + 1;

  // (idx + cnt) wrapped once around the ring
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cnt);
    logic [SUM_W-1:0] s;
    s = SUM_W'(idx) + SUM_W'(cnt);
    if (s >= SUM_W'(HALF_DEPTH)) begin
      s = s - SUM_W'(HALF_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(HALF_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] idx);
    return (idx == '0) ? IDX_W'(HALF_DEPTH - 1) : idx - IDX_W'(1);
  endfunction

  logic signed [DATA_W-1:0] front_mem [HALF_DEPTH];
  logic signed [DATA_W-1:0] back_mem  [HALF_DEPTH];

  logic [IDX_W-1:0] fh_q, fh_d, bh_q, bh_d;
  logic [CNT_W-1:0] fc_q, fc_d, bc_q, bc_d;
  logic signed [DATA_W-1:0] value_q, front_rd_q, back_rd_q;
  logic     bypass_q;
  qmi_out_t res_q;

  logic [N_W-1:0]           n_len;
  logic                     back_we;
  logic [IDX_W-1:0]         back_waddr;
  logic signed [DATA_W-1:0] move_val;

  // Report fill state
  assign n_len = N_W'(fc_q) + N_W'(bc_q);
  always_comb begin
    stat_o.full      = (n_len >= N_W'(CAPACITY));
    stat_o.empty     = (n_len == '0);
    stat_o.few       = (n_len < N_W'(2));
    stat_o.need_move = (bc_q > fc_q);
  end

  // Update pointers and counts
  always_comb begin
    fh_d = fh_q;
    fc_d = fc_q;
    bh_d = bh_q;
    bc_d = bc_q;
    if (cmd_i.push_tail) begin
      bc_d = bc_q + CNT_W'(1);
    end
    if (cmd_i.push_head) begin
      bh_d = ring_dec(bh_q);
      bc_d = bc_q + CNT_W'(1);
    end
    if (cmd_i.pop) begin
      fh_d = ring_inc(fh_q);
      fc_d = fc_q - CNT_W'(1);
    end
    if (cmd_i.move) begin
      bh_d = ring_inc(bh_q);
      bc_d = bc_q - CNT_W'(1);
      fc_d = fc_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q <= '0;
      fc_q <= '0;
      bh_q <= '0;
      bc_q <= '0;
    end else begin
      fh_q <= fh_d;
      fc_q <= fc_d;
      bh_q <= bh_d;
      bc_q <= bc_d;
    end
  end

  // Back ring write: at the tail for a push (or an insert into fewer than two entries), ahead of the head for insert
  assign back_we    = cmd_i.push_tail | cmd_i.push_head;
  assign back_waddr = cmd_i.push_head ? ring_dec(bh_q) : ring_add(bh_q, bc_q);

  always_ff @(posedge clk_i) begin
    if (back_we) begin
      back_mem[back_waddr] <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      back_rd_q <= back_mem[bh_q];
    end
  end

  // Front ring: read head on accept, write tail on a move
  always_ff @(posedge clk_i) begin
    if (cmd_i.move) begin
      front_mem[ring_add(fh_q, fc_q)] <= move_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      front_rd_q <= front_mem[fh_q];
    end
  end

  // Hold the item value; it is the new back head after an insert or a push
  // into an empty back half, which the read above cannot yet see
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      value_q  <= value_i;
      bypass_q <= cmd_i.push_head | (cmd_i.push_tail & (bc_q == '0));
    end
  end

  assign move_val = bypass_q ? value_q : back_rd_q;

  // Load result
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      res_q.popped_value <= cmd_i.pop_ok ? front_rd_q : '0;
      res_q.status       <= cmd_i.status;
    end
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

FILE: src/qmi_ctrl.sv
// Controller: decodes each item and sequences access, rebalance and result.
`default_nettype none

module qmi_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [1:0]          opcode_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  input  qmi_pkg::qmi_stat_t  stat_i,
  output qmi_pkg::qmi_cmd_t   cmd_o
);
  import qmi_pkg::*;

  qmi_state_e state_q, state_d;
  status_e    status_q, status_d;
  logic       pop_ok_q, pop_ok_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, fin;
  status_e    dec_status;
  logic       dec_tail, dec_head, dec_pop;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign fin    = (state_q == S_MOVE) && (!out_valid_q || out_ready_i);

  // Decode the operation against the current fill state
  always_comb begin
    dec_status = STAT_OK;
    dec_tail   = 1'b0;
    dec_head   = 1'b0;
    dec_pop    = 1'b0;
    unique case (opcode_i)
      OP_PUSH: begin
        if (stat_i.full) dec_status = STAT_FULL;
        else             dec_tail   = 1'b1;
      end
      OP_INSERT: begin
        if (stat_i.full)     dec_status = STAT_FULL;
        else if (stat_i.few) dec_tail   = 1'b1;
        else                 dec_head   = 1'b1;
      end
      OP_POP: begin
        if (stat_i.empty) dec_status = STAT_EMPTY;
        else              dec_pop    = 1'b1;
      end
      default: begin
        dec_status = STAT_OK;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_MOVE;
      S_MOVE: if (fin)    state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and held result codes
  always_comb begin
    cmd_o            = '0;
    cmd_o.exec       = accept;
    cmd_o.push_tail  = accept & dec_tail;
    cmd_o.push_head  = accept & dec_head;
    cmd_o.pop        = accept & dec_pop;
    cmd_o.fin        = fin;
    cmd_o.move       = fin & stat_i.need_move;
    cmd_o.pop_ok     = pop_ok_q;
    cmd_o.status     = status_q;
    in_ready_o       = (state_q == S_IDLE);
    out_valid_o      = out_valid_q;

    status_d    = accept ? dec_status : status_q;
    pop_ok_d    = accept ? dec_pop : pop_ok_q;
    out_valid_d = fin ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= STAT_OK;
      pop_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      pop_ok_q    <= pop_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/queue_with_middle_insert.sv
// Top level of the bounded queue with push, pop and middle insert.
`default_nettype none

// Bounded FIFO of signed 32-bit values, CAPACITY entries, kept as two ring
// buffers (front and back half) of (CAPACITY+1)/2 words each. Every item
// gives exactly one result item. The accepting edge does the main access
// (write into the back ring, or read of the front head); the move state then
// moves one element from the back head to the front tail when the halves are
// out of balance, using the registered read of the back ring. The next item
// is accepted as soon as the move state is done, while the previous result
// may still sit in the output register; if that register is still full the
// move state waits for it to drain. The ring memories are not cleared after
// reset; an unwritten entry may be read, but that value is never used.
module queue_with_middle_insert (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  qmi_pkg::qmi_in_t   in_item_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output qmi_pkg::qmi_out_t  out_item_o
);
  import qmi_pkg::*;

  qmi_cmd_t  cmd;
  qmi_stat_t stat;

  qmi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (in_item_i.opcode),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  qmi_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .value_i  (in_item_i.value),
    .stat_o   (stat),
    .result_o (out_item_o)
  );

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Testbench for the queue with middle insert: directed and random items against a two-half model.
`timescale 1ns / 1ps

module tb_top;
  import qmi_pkg::*;

  // Opcode that the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned MAX_REPORTS = 10;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  qmi_in_t  in_item_i;
  logic     out_valid_o;
  logic     out_ready_i;
  qmi_out_t out_item_o;

  // Model of the two halves and the results still to come
  logic signed [DATA_W-1:0] mdl_front[$];
  logic signed [DATA_W-1:0] mdl_back[$];
  qmi_out_t                 pending_results[$];

  int unsigned err_count;
  int unsigned burst_left;
  int unsigned rx_mode;
  int unsigned rx_left;
  logic        rx_toggle;

  queue_with_middle_insert i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // 12 ns clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Move the back head to the front tail when the back half is longer
  function automatic void rebalance_halves();
    if (mdl_back.size() > mdl_front.size()) begin
      mdl_front.push_back(mdl_back.pop_front());
    end
  endfunction

  // Apply one item to the model and return the result it causes
  function automatic qmi_out_t apply_queue_op(qmi_in_t item);
    qmi_out_t    res;
    int unsigned level;
    res   = '0;
    level = mdl_front.size() + mdl_back.size();
    case (item.opcode)
      OP_PUSH, OP_INSERT: begin
        if (level >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          if (item.opcode == OP_PUSH || level < 2) begin
            mdl_back.push_back(item.value);
          end else begin
            mdl_back.push_front(item.value);
          end
          rebalance_halves();
        end
      end
      OP_POP: begin
        if (level == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.popped_value = mdl_front.pop_front();
          rebalance_halves();
        end
      end
      default: begin
        res.status = STAT_OK;
      end
    endcase
    return res;
  endfunction

  function automatic int unsigned queue_level();
    return mdl_front.size() + mdl_back.size();
  endfunction

  // Send one item in bursts with random gaps, record its expected result on acceptance
  task automatic send_item(input logic [1:0] op, input logic [DATA_W-1:0] val);
    qmi_in_t     item;
    int unsigned gap;
    item.opcode = op;
    item.value  = val;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 6);
      end
    end
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    pending_results.push_back(apply_queue_op(item));
    burst_left--;
  endtask

  // Hold the sender off until every expected result has come
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Extremes, empty and short-queue cases, and the ignored opcode
  task automatic test_directed();
    send_item(OP_POP, 32'h1234_5678);
    send_item(OP_PUSH, 32'h7FFF_FFFF);
    send_item(OP_POP, 32'h0000_0000);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_PUSH, 32'h0000_0000);
    send_item(OP_INSERT, 32'h5555_5555);
    send_item(OP_INSERT, 32'hAAAA_AAAA);
    send_item(OP_UNUSED, 32'hDEAD_BEEF);
    send_item(OP_PUSH, 32'h0000_0001);
    repeat (7) send_item(OP_POP, 32'hFFFF_FFFF);
    send_item(OP_UNUSED, 32'h0000_0000);
    send_item(OP_INSERT, 32'h8000_0001);
    send_item(OP_POP, 32'h0000_0000);
  endtask

  // Random mix of operations with a chosen share of pops
  task automatic test_random_mix(input int unsigned count, input int unsigned pop_pct);
    int unsigned pick;
    logic [1:0]  op;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        op = OP_UNUSED;
      end else if (pick < 5 + pop_pct) begin
        op = OP_POP;
      end else if ($urandom_range(0, 1) == 0) begin
        op = OP_PUSH;
      end else begin
        op = OP_INSERT;
      end
      send_item(op, $urandom());
    end
  endtask

  // Fill to capacity, then try pushes and inserts against a full queue
  task automatic test_fill_to_full();
    while (queue_level() < CAPACITY) begin
      send_item(($urandom_range(0, 1) == 0) ? OP_PUSH : OP_INSERT, $urandom());
    end
    send_item(OP_PUSH, $urandom());
    send_item(OP_INSERT, $urandom());
    send_item(OP_UNUSED, $urandom());
    send_item(OP_POP, $urandom());
    send_item(OP_INSERT, $urandom());
    send_item(OP_INSERT, $urandom());
    send_item(OP_PUSH, $urandom());
    wait_for_results();
  endtask

  // Receiver stalls in stretches of differing patterns
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    rx_toggle = ~rx_toggle;
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= rx_toggle;
    endcase
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    qmi_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS) begin
          $display("unexpected result: popped_value %h status %0d",
                   out_item_o.popped_value, out_item_o.status);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.popped_value !== want.popped_value ||
            out_item_o.status !== want.status) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("result differs: popped_value exp %h got %h, status exp %0d got %0d",
                     want.popped_value, out_item_o.popped_value,
                     want.status, out_item_o.status);
          end
        end
      end
    end
  end

  // Stimulus and final verdict
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    err_count   = 0;
    burst_left  = 0;
    rx_mode     = 0;
    rx_left     = 0;
    rx_toggle   = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_mix(400, 45);
    test_fill_to_full();
    test_random_mix(150, 70);

    wait_for_results();
    repeat (16) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("queue_with_middle_insert: match");
    end else begin
      $display("queue_with_middle_insert: mismatch");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #5000000;
    $display("queue_with_middle_insert: mismatch");
    $finish;
  end

endmodule
